// ===== hdl/ccm_pkg.sv =====
// Shared package of the character class token matcher.
// Holds word types, operation and table codes, the state enum and helpers.
// It depends on nothing else.
package ccm_pkg;

   localparam int CCM_NUM_CLASSES  = 32;
   localparam int CCM_CHAR_ENTRIES = 128;
   localparam int CCM_MAX_LEN      = 255;

   // Character codes that may carry a class mask.
   localparam logic [7:0] CCM_FIRST_CODE = 8'd1;
   localparam logic [7:0] CCM_LAST_CODE  = 8'd127;

   // Operation codes.
   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_MATCH  = 2'd2;

   // Table selects.
   localparam logic [1:0] TBL_FIRST  = 2'd0;
   localparam logic [1:0] TBL_SECOND = 2'd1;
   localparam logic [1:0] TBL_FOLLOW = 2'd2;
   localparam logic [1:0] TBL_NONE   = 2'd3;

   // Result kinds and status codes.
   localparam logic KIND_ACK         = 1'b0;
   localparam logic KIND_MATCH       = 1'b1;
   localparam logic STATUS_OK        = 1'b0;
   localparam logic STATUS_BAD_RANGE = 1'b1;

   typedef struct packed {
      logic [1:0]  op;
      logic [1:0]  table_sel;
      logic [31:0] class_bits;
      logic [7:0]  range_start;
      logic [7:0]  range_end;
      logic [7:0]  char_code;
      logic        token_start;
   } ccm_req_type;

   typedef struct packed {
      logic        kind;
      logic        status;
      logic [31:0] match_mask;
      logic [7:0]  match_length;
      logic [4:0]  class_index;
      logic        has_match;
      logic        length_overflow;
   } ccm_rsp_type;

   typedef struct packed {
      logic eval;
      logic token_start;
   } ccm_match_ctrl_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MATCH,
      ST_RANGE
   } ccm_state_type;

   // Index of the lowest set bit, zero when no bit is set.
   function automatic logic [4:0] ccm_lowest_set(input logic [31:0] m);
      logic [4:0] idx;
      idx = '0;
      for (int i = 31; i >= 0; i--) begin
         if (m[i]) begin
            idx = 5'(i);
         end
      end
      return idx;
   endfunction

endpackage

// ===== hdl/char_class_token_matcher_core.sv =====
// Character class token matcher: top level with sequencer and result register.
// A match word reads its table, then is evaluated in ST_MATCH; a range word reads and
// writes back each code from range_start to range_end in ST_RANGE; a rejected range is
// answered at once. Busy stays high until a word is done, so words do not overlap.
// After reset a clearing pass zeroes all 3 * CHAR_ENTRIES table words with busy high.
// Results are shown for one cycle under rsp_strobe; no stall.
module char_class_token_matcher_core #(
   parameter int NUM_CLASSES  = ccm_pkg::CCM_NUM_CLASSES,
   parameter int CHAR_ENTRIES = ccm_pkg::CCM_CHAR_ENTRIES,
   parameter int MAX_LEN      = ccm_pkg::CCM_MAX_LEN
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  ccm_pkg::ccm_req_type req_word,
   output logic                 rsp_strobe,
   output ccm_pkg::ccm_rsp_type rsp_word
);
   import ccm_pkg::*;

   // The three class tables share one memory: first, second and following
   // tables sit one after another, each CHAR_ENTRIES words deep.
   localparam int MASK_W    = (NUM_CLASSES < 32) ? NUM_CLASSES : 32;
   localparam int RAM_DEPTH = 3 * CHAR_ENTRIES;
   localparam int RAM_AW    = $clog2(RAM_DEPTH);
   localparam int CODE_W    = $clog2(CHAR_ENTRIES);
   localparam logic [RAM_AW-1:0] CLR_LAST = RAM_AW'(RAM_DEPTH - 1);

   function automatic logic [RAM_AW-1:0] tab_addr(input logic [1:0] tbl,
                                                  input logic [7:0] code);
      return RAM_AW'(RAM_AW'(tbl) * RAM_AW'(CHAR_ENTRIES)) +
             RAM_AW'(code[CODE_W-1:0]);
   endfunction

   ccm_state_type      state_ff, state_in;
   ccm_req_type        req_ff, req_in;
   logic [7:0]         code_ff, code_in;
   logic [RAM_AW-1:0]  clr_addr_ff, clr_addr_in;
   logic               code_ok_ff, code_ok_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   ccm_rsp_type        rsp_word_ff, rsp_word_in;

   logic               accept;
   logic               is_range_op;
   logic               range_ok;
   logic               char_ok;

   logic               wr_en, rd_en;
   logic [RAM_AW-1:0]  wr_addr, rd_addr;
   logic [MASK_W-1:0]  wr_data, rd_data;
   logic [MASK_W-1:0]  req_bits;
   logic [MASK_W-1:0]  tab_mask;

   logic               ack_emit;
   logic               ack_status;

   ccm_match_ctrl_type mctrl;
   logic               past_second;
   logic               m_valid;
   ccm_rsp_type        m_result;

   assign accept      = start && !busy;
   assign is_range_op = (req_word.op == OP_ADD) || (req_word.op == OP_REMOVE);

   // A range must lie within the codes that carry masks and within the table.
   assign range_ok = (req_word.range_start >= CCM_FIRST_CODE) &&
                     (req_word.range_end <= CCM_LAST_CODE) &&
                     (req_word.range_start <= req_word.range_end) &&
                     ({1'b0, req_word.range_end} < 9'(CHAR_ENTRIES));

   // Code 0 and the upper half of the byte range never match.
   assign char_ok = (req_word.char_code >= CCM_FIRST_CODE) &&
                    (req_word.char_code <= CCM_LAST_CODE) &&
                    ({1'b0, req_word.char_code} < 9'(CHAR_ENTRIES));

   assign req_bits = req_ff.class_bits[MASK_W-1:0];
   assign tab_mask = code_ok_ff ? rd_data : '0;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_addr_ff == CLR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_word.op == OP_MATCH) begin
                  state_in = ST_MATCH;
               end else if (is_range_op && range_ok &&
                            (req_word.table_sel != TBL_NONE)) begin
                  state_in = ST_RANGE;
               end
            end
         end
         ST_MATCH: begin
            state_in = ST_IDLE;
         end
         ST_RANGE: begin
            if (code_ff == req_ff.range_end) begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   // Outputs and datapath control.
   always_comb begin
      busy        = 1'b1;
      wr_en       = 1'b0;
      wr_addr     = '0;
      wr_data     = '0;
      rd_en       = 1'b0;
      rd_addr     = '0;
      ack_emit    = 1'b0;
      ack_status  = STATUS_OK;
      mctrl       = '0;
      code_in     = code_ff;
      clr_addr_in = clr_addr_ff;
      code_ok_in  = code_ok_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en       = 1'b1;
            wr_addr     = clr_addr_ff;
            clr_addr_in = clr_addr_ff + RAM_AW'(1);
         end
         ST_IDLE: begin
            busy = 1'b0;
            if (accept) begin
               if (req_word.op == OP_MATCH) begin
                  // The table follows the pattern position: first on a token
                  // start, then second once, then following.
                  rd_en      = char_ok;
                  code_ok_in = char_ok;
                  if (req_word.token_start) begin
                     rd_addr = tab_addr(TBL_FIRST, req_word.char_code);
                  end else if (past_second) begin
                     rd_addr = tab_addr(TBL_FOLLOW, req_word.char_code);
                  end else begin
                     rd_addr = tab_addr(TBL_SECOND, req_word.char_code);
                  end
               end else if (is_range_op) begin
                  if (range_ok && (req_word.table_sel != TBL_NONE)) begin
                     rd_en   = 1'b1;
                     rd_addr = tab_addr(req_word.table_sel, req_word.range_start);
                     code_in = req_word.range_start;
                  end else begin
                     // Rejected ranges and the spare table select answer at once.
                     ack_emit   = 1'b1;
                     ack_status = range_ok ? STATUS_OK : STATUS_BAD_RANGE;
                  end
               end
            end
         end
         ST_MATCH: begin
            mctrl.eval        = 1'b1;
            mctrl.token_start = req_ff.token_start;
         end
         ST_RANGE: begin
            // Write back one code while the next one is read; the two
            // addresses always differ, so no forwarding is needed.
            wr_en   = 1'b1;
            wr_addr = tab_addr(req_ff.table_sel, code_ff);
            wr_data = (req_ff.op == OP_ADD) ? (rd_data | req_bits)
                                            : (rd_data & ~req_bits);
            if (code_ff == req_ff.range_end) begin
               ack_emit = 1'b1;
            end else begin
               rd_en   = 1'b1;
               code_in = code_ff + 8'd1;
               rd_addr = tab_addr(req_ff.table_sel, code_in);
            end
         end
      endcase
   end

   assign req_in = accept ? req_word : req_ff;

   // Result register: a table acknowledge and a finished match never coincide.
   always_comb begin
      rsp_strobe_in = ack_emit || m_valid;
      if (m_valid) begin
         rsp_word_in = m_result;
      end else begin
         rsp_word_in        = '0;
         rsp_word_in.kind   = KIND_ACK;
         rsp_word_in.status = ack_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_addr_ff   <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      code_ff     <= code_in;
      code_ok_ff  <= code_ok_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

   ccm_table_ram #(
      .DEPTH  (RAM_DEPTH),
      .ADDR_W (RAM_AW),
      .DATA_W (MASK_W)
   ) u_table_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ccm_match_unit #(
      .NUM_CLASSES (NUM_CLASSES),
      .MAX_LEN     (MAX_LEN)
   ) u_match_unit (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (mctrl),
      .tab_mask     (tab_mask),
      .past_second  (past_second),
      .result_valid (m_valid),
      .result       (m_result)
   );

endmodule

// ===== hdl/ccm_table_ram.sv =====
// Class table storage of the character class token matcher.
// Simple dual-port memory with a registered read port; uses no package.
module ccm_table_ram #(
   parameter int DEPTH  = 384,
   parameter int ADDR_W = 9,
   parameter int DATA_W = 32
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/ccm_match_unit.sv =====
// Running match state of the character class token matcher.
// Narrows the class mask per character and forms the match result; uses ccm_pkg.
module ccm_match_unit #(
   parameter int NUM_CLASSES = 32,
   parameter int MAX_LEN     = 255
) (
   input  logic                        clock,
   input  logic                        reset,
   input  ccm_pkg::ccm_match_ctrl_type ctrl,
   input  logic [((NUM_CLASSES < 32) ? NUM_CLASSES : 32)-1:0] tab_mask,
   output logic                        past_second,
   output logic                        result_valid,
   output ccm_pkg::ccm_rsp_type        result
);
   import ccm_pkg::*;

   localparam int MASK_W = (NUM_CLASSES < 32) ? NUM_CLASSES : 32;
   localparam int LEN_W  = $clog2(MAX_LEN + 1);

   logic              active_ff, active_in;
   logic              past_second_ff, past_second_in;
   logic              sat_ff, sat_in;
   logic [MASK_W-1:0] mask_ff, mask_in;
   logic [LEN_W-1:0]  len_ff, len_in;

   logic [MASK_W-1:0] next_mask;
   logic [MASK_W-1:0] emit_mask;
   logic [LEN_W-1:0]  emit_len;
   logic              emit_sat;

   assign next_mask = mask_ff & tab_mask;

   always_comb begin
      active_in      = active_ff;
      past_second_in = past_second_ff;
      sat_in         = sat_ff;
      mask_in        = mask_ff;
      len_in         = len_ff;
      result_valid   = 1'b0;
      emit_mask      = mask_ff;
      emit_len       = len_ff;
      emit_sat       = sat_ff;
      if (ctrl.eval) begin
         if (ctrl.token_start) begin
            // A new token drops whatever match was running.
            past_second_in = 1'b0;
            sat_in         = 1'b0;
            if (tab_mask == '0) begin
               active_in    = 1'b0;
               mask_in      = '0;
               len_in       = '0;
               result_valid = 1'b1;
               emit_mask    = '0;
               emit_len     = '0;
               emit_sat     = 1'b0;
            end else begin
               active_in = 1'b1;
               mask_in   = tab_mask;
               len_in    = LEN_W'(1);
            end
         end else if (active_ff) begin
            past_second_in = 1'b1;
            if (next_mask == '0) begin
               active_in    = 1'b0;
               result_valid = 1'b1;
            end else begin
               mask_in = next_mask;
               if (len_ff < LEN_W'(MAX_LEN)) begin
                  len_in = len_ff + LEN_W'(1);
               end else begin
                  sat_in = 1'b1;
               end
            end
         end
      end
   end

   always_comb begin
      result.kind            = KIND_MATCH;
      result.status          = STATUS_OK;
      result.match_mask      = 32'(emit_mask);
      result.match_length    = 8'(emit_len);
      result.class_index     = ccm_lowest_set(32'(emit_mask));
      result.has_match       = (emit_len != '0);
      result.length_overflow = emit_sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff      <= 1'b0;
         past_second_ff <= 1'b0;
         sat_ff         <= 1'b0;
         mask_ff        <= '0;
         len_ff         <= '0;
      end else begin
         active_ff      <= active_in;
         past_second_ff <= past_second_in;
         sat_ff         <= sat_in;
         mask_ff        <= mask_in;
         len_ff         <= len_in;
      end
   end

   assign past_second = past_second_ff;

endmodule

// ===== hdl/ccm_checker.sv =====
// Port-level checks of the character class token matcher.
// Uses ccm_pkg; bound to char_class_token_matcher_core below.
module ccm_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input ccm_pkg::ccm_req_type req_word,
   input logic                 rsp_strobe,
   input ccm_pkg::ccm_rsp_type rsp_word
);
   import ccm_pkg::*;

   // An acknowledge carries only its status.
   ack_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_word.kind == KIND_ACK)) |->
         (rsp_word.match_mask == '0) && (rsp_word.match_length == '0) &&
         (rsp_word.class_index == '0) && !rsp_word.has_match &&
         !rsp_word.length_overflow)
      else $error("table acknowledge carries match fields");

   // A match result has a mask exactly when it has a length.
   match_consistent: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_word.kind == KIND_MATCH)) |->
         (rsp_word.status == STATUS_OK) &&
         (rsp_word.has_match == (rsp_word.match_mask != '0)))
      else $error("inconsistent match result");

   // A match word is followed by its evaluation cycle.
   match_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_word.op == OP_MATCH)) |=> busy)
      else $error("match word not followed by evaluation");

   // The unused operation code gives no result.
   spare_op_silent: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_word.op != OP_MATCH) && (req_word.op != OP_ADD) &&
       (req_word.op != OP_REMOVE)) |=> !rsp_strobe)
      else $error("result after unused operation");

endmodule

bind char_class_token_matcher_core ccm_checker u_ccm_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_word   (req_word),
   .rsp_strobe (rsp_strobe),
   .rsp_word   (rsp_word)
);

// ===== bench/testbench.sv =====
// Self-checking bench for char_class_token_matcher_core: a queue-fed driver, a strobe monitor
// and an in-bench predictor of the three class tables and the running match.
// Depends on ccm_pkg and the core only.
`timescale 1ns / 100ps

module testbench;
   import ccm_pkg::*;

   // The fourth operation code has no name in the package; the core must ignore it.
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // Where the tables live in the predictor's own store.
   localparam int SEL_FIRST  = 0;
   localparam int SEL_SECOND = 1;
   localparam int SEL_FOLLOW = 2;

   localparam int ITEM_TARGET = 400;     // words offered over the whole run
   localparam int TAIL_WORDS  = 60;      // last stretch of the run, driven without gaps
   localparam int SETTLE      = 4;       // quiet cycles after a drain, for words with no result
   localparam int END_CYCLES  = 10;      // cycles allowed after the last expected result
   localparam int CYCLE_LIMIT = 400000;  // hard stop, well above the slowest correct run

   typedef struct packed {
      logic        drain;  // pause marker: hold off until every result has come
      ccm_req_type word;
   } feed_entry_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   ccm_req_type req_word = '0;
   logic        rsp_strobe;
   ccm_rsp_type rsp_word;

   feed_entry_type feed_q[$];     // words still to be offered to the core
   ccm_rsp_type    owed_rsp[$];   // results the core still owes, oldest first

   // Predictor state: the three class tables and the token being matched.
   logic [31:0] class_tbl [0:2][0:127];
   logic        in_token;
   logic        beyond_second;
   logic [31:0] live_mask;
   logic [7:0]  live_len;
   logic        len_capped;

   int gap_left    = 0;
   int fault_count = 0;
   int cycle_count = 0;
   int word_count  = 0;

   char_class_token_matcher_core dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // ---------------------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------------------

   // Codes 0 and 128 to 255 carry no classes in any table.
   function automatic logic [31:0] lookup_class(input int which, input logic [7:0] code);
      if (code < CCM_FIRST_CODE || code > CCM_LAST_CODE) begin
         return '0;
      end
      return class_tbl[which][code];
   endfunction

   // Queues the result word of a finished match.
   task automatic owe_match(input logic [31:0] mask, input logic [7:0] len, input logic ovf);
      ccm_rsp_type r;
      logic        found;
      r = '0;
      found = 1'b0;
      r.kind = KIND_MATCH;
      r.status = STATUS_OK;
      r.match_mask = mask;
      r.match_length = len;
      for (int i = 0; i < 32; i++) begin
         if (!found && mask[i]) begin
            r.class_index = 5'(i);
            found = 1'b1;
         end
      end
      r.has_match = (len != 8'd0);
      r.length_overflow = ovf;
      owed_rsp.push_back(r);
   endtask

   // Applies one accepted word to the predicted state and queues the result it causes.
   task automatic predict_word(input ccm_req_type w);
      ccm_rsp_type r;
      logic        bad;
      logic [31:0] nxt;
      int          sel;
      if (w.op == OP_ADD || w.op == OP_REMOVE) begin
         bad = (w.range_start > w.range_end) || (w.range_start < CCM_FIRST_CODE) ||
               (w.range_end > CCM_LAST_CODE);
         r = '0;
         r.kind = KIND_ACK;
         r.status = bad ? STATUS_BAD_RANGE : STATUS_OK;
         // A valid range aimed at the fourth table select is acknowledged but changes nothing.
         if (!bad && w.table_sel != TBL_NONE) begin
            sel = (w.table_sel == TBL_FIRST) ? SEL_FIRST :
                  (w.table_sel == TBL_SECOND) ? SEL_SECOND : SEL_FOLLOW;
            for (int c = w.range_start; c <= w.range_end; c++) begin
               if (w.op == OP_ADD) begin
                  class_tbl[sel][c] = class_tbl[sel][c] | w.class_bits;
               end else begin
                  class_tbl[sel][c] = class_tbl[sel][c] & ~w.class_bits;
               end
            end
         end
         owed_rsp.push_back(r);
      end else if (w.op == OP_MATCH) begin
         if (w.token_start) begin
            // A new token drops whatever match was running, without a result.
            nxt = lookup_class(SEL_FIRST, w.char_code);
            in_token = 1'b0;
            beyond_second = 1'b0;
            len_capped = 1'b0;
            live_len = 8'd0;
            live_mask = '0;
            if (nxt == '0) begin
               owe_match('0, 8'd0, 1'b0);
            end else begin
               in_token = 1'b1;
               live_mask = nxt;
               live_len = 8'd1;
            end
         end else if (in_token) begin
            nxt = live_mask &
                  lookup_class(beyond_second ? SEL_FOLLOW : SEL_SECOND, w.char_code);
            beyond_second = 1'b1;
            if (nxt == '0) begin
               owe_match(live_mask, live_len, len_capped);
               in_token = 1'b0;
            end else begin
               live_mask = nxt;
               // The length sticks at its ceiling; the mask still narrows.
               if (live_len < 8'(CCM_MAX_LEN)) begin
                  live_len = live_len + 8'd1;
               end else begin
                  len_capped = 1'b1;
               end
            end
         end
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // Stimulus construction
   // ---------------------------------------------------------------------------------------

   // Fields that the operation does not use are filled at random, so that every bit moves.
   task automatic push_range(input logic [1:0] op, input logic [1:0] sel,
                             input logic [31:0] bits, input logic [7:0] lo,
                             input logic [7:0] hi);
      feed_entry_type e;
      e.drain = 1'b0;
      e.word.op = op;
      e.word.table_sel = sel;
      e.word.class_bits = bits;
      e.word.range_start = lo;
      e.word.range_end = hi;
      e.word.char_code = 8'($urandom);
      e.word.token_start = 1'($urandom);
      feed_q.push_back(e);
      word_count++;
   endtask

   task automatic push_char(input logic [7:0] code, input logic token_start);
      feed_entry_type e;
      e.drain = 1'b0;
      e.word.op = OP_MATCH;
      e.word.table_sel = 2'($urandom);
      e.word.class_bits = $urandom;
      e.word.range_start = 8'($urandom);
      e.word.range_end = 8'($urandom);
      e.word.char_code = code;
      e.word.token_start = token_start;
      feed_q.push_back(e);
      word_count++;
   endtask

   task automatic push_noise();
      feed_entry_type e;
      e.drain = 1'b0;
      e.word = ccm_req_type'({$urandom, $urandom, $urandom});
      feed_q.push_back(e);
      if (e.word.op != OP_UNUSED) begin
         word_count++;
      end
   endtask

   task automatic push_pause();
      feed_entry_type e;
      e = '0;
      e.drain = 1'b1;
      feed_q.push_back(e);
   endtask

   // Mostly identifier and digit characters, so that tokens grow; now and then anything.
   function automatic logic [7:0] pick_char();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) begin
         return 8'($urandom_range(8'h61, 8'h7a));
      end else if (r < 60) begin
         return 8'($urandom_range(8'h30, 8'h39));
      end else if (r < 80) begin
         return 8'($urandom_range(8'h20, 8'h7e));
      end else if (r < 90) begin
         return 8'($urandom_range(1, 127));
      end
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [7:0] edge_code();
      case ($urandom_range(0, 5))
         0: return 8'd0;
         1: return 8'd1;
         2: return 8'd126;
         3: return 8'd127;
         4: return 8'd128;
         default: return 8'd255;
      endcase
   endfunction

   task automatic build_directed();
      // Token start with every table still empty: an empty match.
      push_char("a", 1'b1);
      // An identifier-like set of classes, a digit class and a catch-all top class.
      push_range(OP_ADD, TBL_FIRST,  32'h0000_0003, "a", "z");
      push_range(OP_ADD, TBL_SECOND, 32'h0000_0003, "a", "z");
      push_range(OP_ADD, TBL_FOLLOW, 32'h0000_0003, "a", "z");
      push_range(OP_ADD, TBL_FIRST,  32'h0000_0004, "0", "9");
      push_range(OP_ADD, TBL_SECOND, 32'h0000_0006, "0", "9");
      push_range(OP_ADD, TBL_FOLLOW, 32'h0000_0006, "0", "9");
      push_range(OP_ADD, TBL_FOLLOW, 32'h8000_0000, 8'd1, 8'd127);
      push_range(OP_ADD, TBL_FIRST,  32'h8000_0000, 8'd127, 8'd127);
      push_range(OP_ADD, TBL_SECOND, 32'hffff_ffff, 8'd1, 8'd1);
      // Rejected ranges: start at zero, start past end, end past the table, all-ones codes.
      push_range(OP_ADD, TBL_FIRST, 32'hffff_ffff, 8'd0, 8'd5);
      push_range(OP_REMOVE, TBL_SECOND, 32'hffff_ffff, 8'd10, 8'd9);
      push_range(OP_ADD, TBL_FOLLOW, 32'hffff_ffff, 8'd1, 8'd128);
      push_range(OP_REMOVE, TBL_FIRST, 32'hffff_ffff, 8'd255, 8'd255);
      // A valid range on the fourth table select: acknowledged, no table changes.
      push_range(OP_ADD, TBL_NONE, 32'hffff_ffff, 8'd1, 8'd127);
      push_range(OP_UNUSED, TBL_FIRST, 32'hffff_ffff, "a", "z");
      // Digits lose their first-table class for a while, then get it back.
      push_range(OP_REMOVE, TBL_FIRST, 32'h0000_0004, "0", "9");
      push_char("a", 1'b1);
      push_char("b", 1'b0);
      push_char("0", 1'b0);
      push_char(" ", 1'b0);
      push_char("0", 1'b1);
      push_range(OP_ADD, TBL_FIRST, 32'h0000_0000, "0", "9");
      push_range(OP_ADD, TBL_FIRST, 32'h0000_0004, "0", "9");
      // Top class through code 127, then code 1 in the second table, then a high byte.
      push_char(8'd127, 1'b1);
      push_char(8'd1, 1'b0);
      push_char(8'd200, 1'b0);
      // Codes that can never match, used to start tokens.
      push_char(8'd0, 1'b1);
      push_char(8'd128, 1'b1);
      push_char(8'd255, 1'b1);
      // A running match restarted by a new token, then a stray character with no token open.
      push_char("a", 1'b1);
      push_char("q", 1'b1);
      push_char("c", 1'b0);
      push_char(8'd0, 1'b0);
      push_char("x", 1'b0);
      // One token that runs through the length ceiling and a few characters past it.
      push_char("a", 1'b1);
      repeat (CCM_MAX_LEN + 4) push_char("a", 1'b0);
      push_char(" ", 1'b0);
      push_pause();
   endtask

   task automatic build_random();
      int          r;
      logic [7:0]  lo;
      logic [7:0]  hi;
      logic [31:0] bits;
      while (word_count < ITEM_TARGET) begin
         r = $urandom_range(0, 99);
         if (r < 70) begin
            // A well-formed token with random content.
            push_char(pick_char(), 1'b1);
            repeat ($urandom_range(0, 8)) push_char(pick_char(), 1'b0);
         end else if (r < 82) begin
            bits = ($urandom_range(0, 1) == 0) ? (32'd1 << $urandom_range(0, 31)) : $urandom;
            case ($urandom_range(0, 6))
               0: begin
                  lo = edge_code();
                  hi = edge_code();
               end
               1: begin
                  lo = 8'($urandom);
                  hi = 8'($urandom);
               end
               default: begin
                  lo = 8'($urandom_range(1, 127));
                  hi = 8'(((lo + $urandom_range(0, 7)) > 127) ? 127 : lo + $urandom_range(0, 7));
               end
            endcase
            push_range(($urandom_range(0, 4) < 3) ? OP_ADD : OP_REMOVE, 2'($urandom), bits, lo, hi);
         end else if (r < 92) begin
            push_noise();
         end else if (r < 95) begin
            // No pauses in the closing stretch, which runs without idling.
            if (word_count < ITEM_TARGET - TAIL_WORDS) begin
               push_pause();
            end
         end else begin
            // A broken sequence: characters with no token start in front of them.
            repeat ($urandom_range(1, 4)) push_char(pick_char(), 1'b0);
         end
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // Driver: offers one word at a time; a word is taken at an edge where start is high and
   // busy is low. Idle gaps follow some words, except near the end of the run.
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin : driver
      logic           taken;
      feed_entry_type e;
      taken = start && (busy === 1'b0);
      if (reset) begin
         start <= 1'b0;
         req_word <= '0;
         gap_left = 0;
      end else begin
         if (taken) begin
            predict_word(req_word);
            if (feed_q.size() > TAIL_WORDS && $urandom_range(0, 5) == 0) begin
               gap_left = $urandom_range(1, 9);
            end
         end
         if (start && !taken) begin
            // The word on offer stays until the core takes it.
         end else if (gap_left != 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (feed_q.size() == 0) begin
            start <= 1'b0;
         end else if (feed_q[0].drain) begin
            // Hold off until nothing is owed and the core has gone quiet, then settle a little
            // longer for a match word that ends without a result.
            start <= 1'b0;
            if (!taken && owed_rsp.size() == 0 && busy === 1'b0) begin
               void'(feed_q.pop_front());
               gap_left = SETTLE;
            end
         end else begin
            e = feed_q.pop_front();
            req_word <= e.word;
            start <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Monitor: each strobed result is checked field by field against the oldest one owed.
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      ccm_rsp_type want;
      logic        differs;
      if (!reset && rsp_strobe === 1'b1) begin
         if (owed_rsp.size() == 0) begin
            if (fault_count < 10) begin
               $display("cycle %0d: result word with none owed: %h", cycle_count, rsp_word);
            end
            fault_count++;
         end else begin
            want = owed_rsp.pop_front();
            differs = (rsp_word.kind !== want.kind) || (rsp_word.status !== want.status) ||
                      (rsp_word.match_mask !== want.match_mask) ||
                      (rsp_word.match_length !== want.match_length) ||
                      (rsp_word.class_index !== want.class_index) ||
                      (rsp_word.has_match !== want.has_match) ||
                      (rsp_word.length_overflow !== want.length_overflow);
            if (differs) begin
               if (fault_count < 10) begin
                  $display("cycle %0d: expected kind %b status %b mask %h len %0d idx %0d has %b ovf %b",
                           cycle_count, want.kind, want.status, want.match_mask,
                           want.match_length, want.class_index, want.has_match,
                           want.length_overflow);
                  $display("cycle %0d:   actual kind %b status %b mask %h len %0d idx %0d has %b ovf %b",
                           cycle_count, rsp_word.kind, rsp_word.status, rsp_word.match_mask,
                           rsp_word.match_length, rsp_word.class_index, rsp_word.has_match,
                           rsp_word.length_overflow);
               end
               fault_count++;
            end
         end
      end
   end

   // The run is cut short if it goes on far longer than any correct run could.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      for (int t = 0; t < 3; t++) begin
         for (int c = 0; c < 128; c++) begin
            class_tbl[t][c] = '0;
         end
      end
      in_token = 1'b0;
      beyond_second = 1'b0;
      live_mask = '0;
      live_len = 8'd0;
      len_capped = 1'b0;
      build_directed();
      build_random();

      // Reset is held at the start of the run; the core then clears its tables with busy high.
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (feed_q.size() != 0 || start) @(posedge clock);
      while (owed_rsp.size() != 0) @(posedge clock);
      repeat (END_CYCLES) @(posedge clock);

      if (fault_count == 0 && owed_rsp.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
